// File: design/lppd_pkg.sv
package lppd_pkg;

    localparam logic [31:0] IMAGE_HEAD = 32'hABCDEEFF;
    localparam int unsigned HDR_BYTES  = 8;
    localparam int unsigned KEY_BYTES  = 8;
    localparam int unsigned WORD_BITS  = 32;

    // modulo unit: 64-bit dividend, DIV_BITS bits per cycle
    localparam int unsigned DIV_BITS   = 4;
    localparam int unsigned DIV_STEPS  = 64 / DIV_BITS;

    localparam logic [1:0] CFG_MAX_LEN = 2'd0;
    localparam logic [1:0] CFG_SND_CNT = 2'd1;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ERR  = 1'b1;

    localparam logic ERR_TOO_LONG  = 1'b0;
    localparam logic ERR_TOO_SHORT = 1'b1;

    typedef enum logic [6:0] {
        ST_HEADER  = 7'b0000001,
        ST_KEY     = 7'b0000010,
        ST_HASH    = 7'b0000100,
        ST_BURST   = 7'b0001000,
        ST_FORWARD = 7'b0010000,
        ST_SKIP    = 7'b0100000,
        ST_CLOSED  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic hdr_shift;
        logic key_shift;
        logic cnt_inc;
        logic cnt_clr;
        logic hash_start;
        logic hash_step;
        logic burst_step;
        logic emit_fwd;
        logic emit_err;
        logic err_code;
    } t_cmd;

    typedef struct packed {
        logic hdr_last;
        logic too_long;
        logic short_image;
        logic is_image;
        logic len_zero;
        logic key_last;
        logic pay_last;
        logic hash_last;
        logic burst_last;
        logic burst_short;
        logic out_free;
    } t_status;

endpackage

// File: design/lppd_ctrl.sv
module lppd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  lppd_pkg::t_status i_sts,
    output lppd_pkg::t_cmd    o_cmd
);
    import lppd_pkg::*;

    t_state r_state, n_state;
    logic   rdy;
    logic   acc;

    always_comb begin
        unique case (r_state)
            ST_HEADER, ST_KEY, ST_FORWARD, ST_SKIP: rdy = i_sts.out_free;
            ST_CLOSED:                              rdy = 1'b1;
            default:                                rdy = 1'b0;
        endcase
    end

    assign o_stall = !rdy;
    assign acc     = i_valid && rdy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_HEADER: begin
                if (acc) begin
                    o_cmd.hdr_shift = 1'b1;
                    if (i_sts.hdr_last) begin
                        o_cmd.cnt_clr = 1'b1;
                        priority if (i_sts.too_long) begin
                            o_cmd.emit_err = 1'b1;
                            o_cmd.err_code = ERR_TOO_LONG;
                            n_state        = ST_CLOSED;
                        end else if (i_sts.short_image) begin
                            o_cmd.emit_err = 1'b1;
                            o_cmd.err_code = ERR_TOO_SHORT;
                            n_state        = ST_CLOSED;
                        end else if (i_sts.is_image) begin
                            n_state = ST_KEY;
                        end else if (i_sts.len_zero) begin
                            n_state = ST_HEADER;
                        end else begin
                            n_state = ST_SKIP;
                        end
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                    end
                end
            end
            ST_KEY: begin
                if (acc) begin
                    o_cmd.key_shift = 1'b1;
                    o_cmd.cnt_inc   = 1'b1;
                    if (i_sts.key_last) begin
                        o_cmd.hash_start = 1'b1;
                        n_state          = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_sts.hash_last) begin
                    n_state = ST_BURST;
                end
            end
            ST_BURST: begin
                if (i_sts.out_free) begin
                    o_cmd.burst_step = 1'b1;
                    if (i_sts.burst_last) begin
                        if (i_sts.burst_short) begin
                            o_cmd.cnt_clr = 1'b1;
                            n_state       = ST_HEADER;
                        end else begin
                            n_state = ST_FORWARD;
                        end
                    end
                end
            end
            ST_FORWARD: begin
                if (acc) begin
                    o_cmd.emit_fwd = 1'b1;
                    if (i_sts.pay_last) begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = ST_HEADER;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                    end
                end
            end
            ST_SKIP: begin
                if (acc) begin
                    if (i_sts.pay_last) begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = ST_HEADER;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                    end
                end
            end
            ST_CLOSED: begin
                n_state = ST_CLOSED;
            end
            default: begin
                n_state = ST_HEADER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HEADER;
        end else begin
            r_state <= n_state;
        end
    end

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_fwd || o_cmd.emit_err || o_cmd.burst_step) |-> i_sts.out_free)
        else $error("result issued while output word is occupied");

    a_closed_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLOSED) |=> (r_state == ST_CLOSED))
        else $error("closed stream reopened without reset");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_HASH) || (r_state == ST_BURST)) |-> o_stall)
        else $error("input word taken during hash or burst");

endmodule

// File: design/lppd_dp.sv
module lppd_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic [7:0]        i_byte_in,
    input  logic              i_stall,
    input  lppd_pkg::t_cmd    i_cmd,
    output lppd_pkg::t_status o_sts,
    output logic              o_valid,
    output logic              o_out_kind,
    output logic [7:0]        o_data_byte,
    output logic [7:0]        o_dest_index,
    output logic              o_packet_end,
    output logic              o_run_last,
    output logic              o_error_code
);
    import lppd_pkg::*;

    localparam int unsigned HCNT_W = $clog2(DIV_STEPS);

    logic [31:0]       r_max_len;
    logic [8:0]        r_snd_cnt;
    logic [31:0]       r_cnt;
    logic [31:0]       r_head;
    logic [31:0]       r_len;
    logic [63:0]       r_key;
    logic [63:0]       r_div_sh;
    logic [7:0]        r_rem;
    logic [HCNT_W-1:0] r_hcnt;
    logic [2:0]        r_bcnt;
    logic [7:0]        r_dest;

    logic              r_out_valid;
    logic              r_out_kind;
    logic [7:0]        r_out_data;
    logic [7:0]        r_out_dest;
    logic              r_out_pend;
    logic              r_out_last;
    logic              r_out_code;

    logic [31:0]       len_next;
    logic [63:0]       key_next;
    logic [31:0]       hash_h;
    logic [31:0]       cnt_inc;
    logic [8:0]        n_eff;
    logic [7:0]        rem_next;
    logic              burst_pend;

    assign len_next = {r_len[23:0], i_byte_in};
    assign key_next = {r_key[55:0], i_byte_in};
    assign hash_h   = key_next[31:0] ^ key_next[63:32];
    assign cnt_inc  = r_cnt + 32'd1;

    // zero counts as one, anything above 256 as 256
    always_comb begin
        priority if (r_snd_cnt == 9'd0) begin
            n_eff = 9'd1;
        end else if (r_snd_cnt > 9'd256) begin
            n_eff = 9'd256;
        end else begin
            n_eff = r_snd_cnt;
        end
    end

    // restoring modulo, DIV_BITS dividend bits per cycle
    always_comb begin
        logic [8:0] t;
        logic [7:0] rem;
        rem = r_rem;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {rem, r_div_sh[63-i]};
            if (t >= n_eff) begin
                t = t - n_eff;
            end
            rem = t[7:0];
        end
        rem_next = rem;
    end

    assign burst_pend = (r_bcnt == 3'(KEY_BYTES - 1)) && (r_len == 32'(KEY_BYTES));

    always_comb begin
        o_sts.hdr_last    = (r_cnt == 32'(HDR_BYTES - 1));
        o_sts.too_long    = (len_next > r_max_len);
        o_sts.is_image    = (r_head == IMAGE_HEAD);
        o_sts.short_image = (r_head == IMAGE_HEAD) && (len_next <= 32'(KEY_BYTES));
        o_sts.len_zero    = (len_next == 32'd0);
        o_sts.key_last    = (r_cnt == 32'(KEY_BYTES - 1));
        o_sts.pay_last    = (cnt_inc >= r_len);
        o_sts.hash_last   = (r_hcnt == HCNT_W'(DIV_STEPS - 1));
        o_sts.burst_last  = (r_bcnt == 3'(KEY_BYTES - 1));
        o_sts.burst_short = (r_len <= 32'(KEY_BYTES));
        o_sts.out_free    = !r_out_valid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 32'd1048576;
            r_snd_cnt <= 9'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MAX_LEN) begin
                r_max_len <= i_cfg_data;
            end else if (i_cfg_index == CFG_SND_CNT) begin
                r_snd_cnt <= i_cfg_data[8:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_head <= '0;
            r_len  <= '0;
            r_key  <= '0;
            r_dest <= '0;
            r_hcnt <= '0;
            r_bcnt <= '0;
            r_rem  <= '0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= cnt_inc;
            end
            if (i_cmd.hdr_shift) begin
                if (r_cnt < 32'(WORD_BITS / 8)) begin
                    r_head <= {r_head[23:0], i_byte_in};
                end else begin
                    r_len <= len_next;
                end
            end
            if (i_cmd.key_shift) begin
                r_key <= key_next;
            end else if (i_cmd.burst_step) begin
                r_key <= {r_key[55:0], 8'd0};
            end
            if (i_cmd.hash_start) begin
                r_div_sh <= {{32{hash_h[31]}}, hash_h};
                r_rem    <= '0;
                r_hcnt   <= '0;
            end else if (i_cmd.hash_step) begin
                r_div_sh <= {r_div_sh[63-DIV_BITS:0], {DIV_BITS{1'b0}}};
                r_rem    <= rem_next;
                r_hcnt   <= r_hcnt + HCNT_W'(1);
                if (o_sts.hash_last) begin
                    r_dest <= rem_next;
                    r_bcnt <= '0;
                end
            end
            if (i_cmd.burst_step) begin
                r_bcnt <= r_bcnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_fwd || i_cmd.emit_err || i_cmd.burst_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.emit_err) begin
            r_out_kind <= KIND_ERR;
            r_out_data <= '0;
            r_out_dest <= '0;
            r_out_pend <= 1'b0;
            r_out_last <= 1'b1;
            r_out_code <= i_cmd.err_code;
        end else if (i_cmd.emit_fwd) begin
            r_out_kind <= KIND_DATA;
            r_out_data <= i_byte_in;
            r_out_dest <= r_dest;
            r_out_pend <= o_sts.pay_last;
            r_out_last <= 1'b1;
            r_out_code <= 1'b0;
        end else if (i_cmd.burst_step) begin
            r_out_kind <= KIND_DATA;
            r_out_data <= r_key[63:56];
            r_out_dest <= r_dest;
            r_out_pend <= burst_pend;
            r_out_last <= o_sts.burst_last;
            r_out_code <= 1'b0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_data_byte  = r_out_data;
    assign o_dest_index = r_out_dest;
    assign o_packet_end = r_out_pend;
    assign o_run_last   = r_out_last;
    assign o_error_code = r_out_code;

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hash_step |=> ({1'b0, r_rem} < n_eff))
        else $error("hash remainder out of range");

endmodule

// File: design/length_prefixed_packet_dispatcher_top.sv
// Length-prefixed packet dispatcher.
// Input channel: one stream byte per word on i_byte_in, taken when i_valid is
// high and o_stall is low. Each packet is a 4-byte head, a 4-byte big-endian
// length, then the payload.
// Output channel: one result per word (o_valid / i_stall): a forwarded byte
// tagged with its destination, or an error report. o_run_last marks the last
// result caused by one input byte.
// Header and skipped bytes give no result. A forwarded
// payload byte leaves in the cycle after it is taken; one byte per cycle is
// sustained while the receiver does not stall.
// The eighth key byte of an image packet starts a 4-bit-per-cycle modulo unit,
// then the 8 key bytes leave one per cycle while the receiver does not stall;
// input is held off during the modulo unit and the key burst.
// A header error gives one error report and then the stream is closed: later
// bytes are taken and dropped until reset.
// Reset (synchronous, active low) restores max_packet_len = 1048576,
// sender_count = 1, and an empty header state. A stalled receiver holds the
// output word; an open stream takes input only while it is free or draining.
module length_prefixed_packet_dispatcher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_out_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_dest_index,
    output logic        o_packet_end,
    output logic        o_run_last,
    output logic        o_error_code
);
    import lppd_pkg::*;

    t_cmd    cmd;
    t_status sts;

    lppd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lppd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_byte_in    (i_byte_in),
        .i_stall      (i_stall),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_valid      (o_valid),
        .o_out_kind   (o_out_kind),
        .o_data_byte  (o_data_byte),
        .o_dest_index (o_dest_index),
        .o_packet_end (o_packet_end),
        .o_run_last   (o_run_last),
        .o_error_code (o_error_code)
    );

endmodule

// File: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lppd_pkg::*;

    // indexes past the register list; writes there must change nothing
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned RAND_BYTES   = 140;
    localparam int unsigned SET_BYTES    = 28;

    typedef enum logic [1:0] {P_HEADER, P_KEY, P_FORWARD, P_SKIP} t_parse_phase;
    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN} t_rx_mode;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [7:0] dest;
        logic       pend;
        logic       last;
        logic       code;
    } t_out_word;

    class dispatch_tracker;
        logic [31:0]  max_len;
        logic [8:0]   snd_cnt;
        t_parse_phase phase;
        logic [31:0]  count;
        logic [31:0]  head;
        logic [31:0]  len;
        logic [63:0]  key;
        logic [7:0]   dest;
        bit           closed;
        t_out_word    owed_words[$];
        int           err_count;

        function new();
            max_len   = 32'd1048576;
            snd_cnt   = 9'd1;
            phase     = P_HEADER;
            count     = '0;
            head      = '0;
            len       = '0;
            key       = '0;
            dest      = '0;
            closed    = 1'b0;
            err_count = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == CFG_MAX_LEN) begin
                max_len = val;
            end else if (idx == CFG_SND_CNT) begin
                snd_cnt = val[8:0];
            end
        endfunction

        // xor of key halves, sign-extended, then unsigned modulo the clamped count
        function logic [7:0] hash_dest(logic [63:0] k);
            logic [31:0] h;
            logic [63:0] wide;
            logic [63:0] n;
            h    = k[31:0] ^ k[63:32];
            wide = {{32{h[31]}}, h};
            if (snd_cnt == 9'd0) begin
                n = 64'd1;
            end else if (snd_cnt > 9'd256) begin
                n = 64'd256;
            end else begin
                n = 64'(snd_cnt);
            end
            return 8'(wide % n);
        endfunction

        function void restart();
            phase = P_HEADER;
            count = '0;
            head  = '0;
            len   = '0;
        endfunction

        function void take_byte(logic [7:0] b);
            t_out_word w;
            w = '0;
            if (closed) begin
                return;
            end
            case (phase)
                P_HEADER: begin
                    if (count < 4) begin
                        head = {head[23:0], b};
                    end else begin
                        len = {len[23:0], b};
                    end
                    count++;
                    if (count == HDR_BYTES) begin
                        count = '0;
                        if (len > max_len || (head == IMAGE_HEAD && len <= KEY_BYTES)) begin
                            closed = 1'b1;
                            w.kind = KIND_ERR;
                            w.last = 1'b1;
                            w.code = (len > max_len) ? ERR_TOO_LONG : ERR_TOO_SHORT;
                            owed_words.push_back(w);
                        end else if (head == IMAGE_HEAD) begin
                            key   = '0;
                            phase = P_KEY;
                        end else if (len != 0) begin
                            phase = P_SKIP;
                        end
                    end
                end
                P_KEY: begin
                    key = {key[55:0], b};
                    count++;
                    if (count == KEY_BYTES) begin
                        dest = hash_dest(key);
                        for (int i = 0; i < KEY_BYTES; i++) begin
                            w.kind = KIND_DATA;
                            w.data = key[63 - 8 * i -: 8];
                            w.dest = dest;
                            w.last = (i == KEY_BYTES - 1);
                            w.pend = w.last && (len == KEY_BYTES);
                            w.code = 1'b0;
                            owed_words.push_back(w);
                        end
                        if (len <= KEY_BYTES) begin
                            restart();
                        end else begin
                            phase = P_FORWARD;
                        end
                    end
                end
                P_FORWARD: begin
                    count++;
                    w.kind = KIND_DATA;
                    w.data = b;
                    w.dest = dest;
                    w.pend = (count >= len);
                    w.last = 1'b1;
                    owed_words.push_back(w);
                    if (w.pend) begin
                        restart();
                    end
                end
                default: begin
                    count++;
                    if (count >= len) begin
                        restart();
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                err_count++;
            end
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (owed_words.size() == 0) begin
                $display("%0t: unexpected word kind %0h data %0h dest %0h, nothing expected",
                         $time, got.kind, got.data, got.dest);
                err_count++;
            end else begin
                want = owed_words.pop_front();
                compare_field("out_kind", want.kind, got.kind);
                compare_field("data_byte", want.data, got.data);
                compare_field("dest_index", want.dest, got.dest);
                compare_field("packet_end", want.pend, got.pend);
                compare_field("run_last", want.last, got.last);
                compare_field("error_code", want.code, got.code);
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_byte_in   = '0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_out_kind;
    logic [7:0]  o_data_byte;
    logic [7:0]  o_dest_index;
    logic        o_packet_end;
    logic        o_run_last;
    logic        o_error_code;

    dispatch_tracker sb = new();

    int unsigned bytes_sent  = 0;
    int unsigned burst_left  = 0;
    bit          tx_gaps     = 1'b1;
    int unsigned words_seen  = 0;
    int unsigned rx_tick     = 0;
    int unsigned hold_left   = 0;
    bit          held_once   = 1'b0;
    t_rx_mode    rx_mode     = RX_RANDOM;

    length_prefixed_packet_dispatcher_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_byte_in    (i_byte_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_kind   (o_out_kind),
        .o_data_byte  (o_data_byte),
        .o_dest_index (o_dest_index),
        .o_packet_end (o_packet_end),
        .o_run_last   (o_run_last),
        .o_error_code (o_error_code)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: check each taken word, then pick the next stall value
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_word({o_out_kind, o_data_byte, o_dest_index,
                           o_packet_end, o_run_last, o_error_code});
            words_seen++;
        end
        rx_tick++;
        if (rx_tick % 97 == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!held_once && words_seen >= 80) begin
            // long hold-off so the block backs up into its input
            held_once = 1'b1;
            hold_left = 400;
            i_stall <= 1'b1;
        end else begin
            case (rx_mode)
                RX_OPEN:    i_stall <= 1'b0;
                RX_RANDOM:  i_stall <= ($urandom_range(0, 99) < 35);
                default:    i_stall <= (rx_tick % 5 < 2);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (tx_gaps) begin
                gap = $urandom_range(1, 6);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid   <= 1'b1;
        i_byte_in <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_byte(b);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) begin
            send_byte(w[8 * i +: 8]);
        end
    endtask

    task automatic send_image(input logic [63:0] k, input logic [31:0] n);
        send_word(IMAGE_HEAD);
        send_word(n);
        for (int i = 7; i >= 0; i--) begin
            send_byte(k[8 * i +: 8]);
        end
        repeat (n - KEY_BYTES) send_byte(8'($urandom));
    endtask

    task automatic send_other(input logic [31:0] h, input logic [31:0] n);
        send_word(h);
        send_word(n);
        repeat (n) send_byte(8'($urandom));
    endtask

    // drop valid, wait for every owed word, then let the block settle
    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] max_len, input logic [31:0] snd_raw);
        go_idle();
        write_reg(CFG_MAX_LEN, max_len);
        write_reg(CFG_SND_CNT, snd_raw);
    endtask

    task automatic random_packet();
        int unsigned pick;
        logic [31:0] n;
        logic [31:0] h;
        pick = $urandom_range(0, 99);
        if (pick < 70 && sb.max_len >= KEY_BYTES + 1) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 300) : $urandom_range(9, 40);
            if (n > sb.max_len) begin
                n = sb.max_len;
            end
            send_image({$urandom, $urandom}, n);
        end else begin
            // random heads, some one bit away from the image head
            h = (pick < 85) ? $urandom : IMAGE_HEAD ^ (32'd1 << $urandom_range(0, 31));
            if (h == IMAGE_HEAD) begin
                h = ~h;
            end
            n = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 30));
            if (n > sb.max_len) begin
                n = sb.max_len;
            end
            send_other(h, n);
        end
    endtask

    initial begin
        int unsigned rand_base;
        int unsigned set_base;
        int unsigned setting;
        logic [31:0] bad_len;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: one destination, 1 MiB limit
        send_image(64'h0, 9);
        send_other(32'h0, 0);
        send_other(32'h1234_5678, 3);
        send_other(IMAGE_HEAD ^ 32'h1, 10);
        send_image(64'hFFFF_FFFF_FFFF_FFFF, 12);

        configure(32'hFFFF_FFFF, 32'd256);
        send_image(64'hFFFF_FFFF_0000_0000, 9);
        send_image(64'h8000_0000_0000_0000, 10);
        send_image(64'h0123_4567_89AB_CDEF, 9);

        // three destinations, garbage above the count field
        configure(32'd1048576, 32'hFFFF_FE03);
        send_image(64'h8000_0000_0000_0000, 9);
        send_image(64'h7FFF_FFFF_0000_0000, 11);
        send_image(64'h0000_0000_0000_0001, 9);

        // a count of zero acts as one; length equal to the limit passes
        configure(32'd9, 32'd0);
        send_image({$urandom, $urandom}, 9);
        send_other($urandom | 32'h1, 9);
        send_other(32'h0, 0);

        configure(32'd0, 32'd257);
        send_other(32'h0, 0);
        send_other(IMAGE_HEAD ^ 32'h8000_0000, 0);

        configure(32'd64, 32'd511);
        write_reg(CFG_SPARE_LO, 32'h0);
        write_reg(CFG_SPARE_HI, 32'd5);
        send_image({$urandom, $urandom}, 64);
        send_image(64'hFFFF_FFFF_7FFF_FFFF, 9);

        rand_base = bytes_sent;
        setting   = 0;
        while (bytes_sent - rand_base < RAND_BYTES) begin
            case (setting % 5)
                0: configure(32'hFFFF_FFFF, 32'd256);
                1: configure($urandom_range(40, 1048576), $urandom_range(1, 255));
                2: configure(32'd9 + $urandom_range(0, 31), $urandom_range(2, 16));
                3: configure(32'd1048576,
                             ($urandom & 32'hFFFF_FE00) | $urandom_range(257, 511));
                default: configure($urandom | 32'h40, $urandom_range(1, 256));
            endcase
            tx_gaps  = (setting % 3 != 2);
            set_base = bytes_sent;
            while (bytes_sent - set_base < SET_BYTES) begin
                random_packet();
            end
            setting++;
        end

        // one header error closes the stream for the rest of the run
        tx_gaps = 1'b1;
        configure($urandom_range(9, 1000), $urandom_range(1, 256));
        if ($urandom_range(0, 1) == 1) begin
            bad_len = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : sb.max_len + 1;
            send_word($urandom);
            send_word(bad_len);
        end else begin
            send_word(IMAGE_HEAD);
            send_word($urandom_range(0, 8));
        end
        repeat (12) send_byte(8'($urandom));
        go_idle();

        if (sb.err_count == 0) begin
            $display("[length_prefixed_packet_dispatcher_top] OK");
        end else begin
            $display("[length_prefixed_packet_dispatcher_top] ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[length_prefixed_packet_dispatcher_top] ERROR");
        $finish;
    end

endmodule
